FILE: hdl/lcdc_pkg.sv
// lcdc_pkg: constants, codes and types for the layered character display compositor
// no dependencies; imported by layered_char_display_compositor
`timescale 1ns / 1ps
`default_nettype none

package lcdc_pkg;

    // display geometry and layer count
    localparam int LAYERS = 4;
    localparam int ROWS   = 2;
    localparam int COLS   = 16;

    // derived widths
    localparam int LAY_W  = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W  = $clog2(COLS);
    localparam int CELLS  = ROWS * COLS;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    // field widths fixed by the interface
    localparam int OP_W     = 3;
    localparam int ROWF_W   = 2;
    localparam int COLF_W   = 6;
    localparam int LAYF_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int IN_W     = 24;
    localparam int MASK_W   = 4;

    // character and command bytes
    localparam logic [7:0] SPACE_CODE = 8'h20;
    localparam logic [7:0] ADDR_CMD   = 8'h80;
    localparam logic [7:0] ROW1_BASE  = 8'h40;
    localparam logic [7:0] ADDR_MASK  = 8'h7F;

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE_CHAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR_LAYER = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR_LINE  = 3'd2;
    localparam logic [OP_W-1:0] OP_MOVE_CURSOR = 3'd3;
    localparam logic [OP_W-1:0] OP_REFRESH     = 3'd4;

    // one memory word holds a cell of every layer
    typedef logic [LAYERS-1:0][7:0] lanes_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROWCMD,
        ST_READ,
        ST_CMP,
        ST_REPOS,
        ST_DATA,
        ST_CURSOR
    } state_t;

endpackage

`default_nettype wire

FILE: hdl/layered_char_display_compositor.sv
// layered_char_display_compositor: layer memory, shown-copy memory and refresh sequencer
// depends on lcdc_pkg
`timescale 1ns / 1ps
`default_nettype none

//  channel   dir  handshake            payload
//  s_        in   s_tvalid / s_tready  s_tdata: operation, row, col, layer, character
//  m_        out  m_tvalid / m_tready  m_tdata: bus_byte, m_tuser: register_select, m_tlast
//  cfg_      in   cfg_we               cfg_wdata: layer_hidden_mask
//
// write char, clear layer, clear line and unknown operations finish in ST_IDLE; move cursor
// also passes through ST_CURSOR. A refresh walks the cells one at a time through the single
// read port of the layer memory: a row command per row, a read and a compare per cell, a
// data byte per changed cell and a re-address command after skipped cells; m_tready low
// stalls it. Reset needs no clearing pass: the layer and shown memories carry per-entry
// valid bits. A result waits in the output register while the next item is accepted.

module layered_char_display_compositor (
    input  wire                       aclk,
    input  wire                       aresetn,
    // operation [2:0], row [4:3], col [10:5], layer [12:11], character [20:13]
    input  wire [lcdc_pkg::IN_W-1:0]  s_tdata,
    input  wire                       s_tvalid,
    output logic                      s_tready,
    // bus_byte [7:0]
    output logic [7:0]                m_tdata,
    // register_select [0]
    output logic [0:0]                m_tuser,
    output logic                      m_tlast,
    output logic                      m_tvalid,
    input  wire                       m_tready,
    input  wire                       cfg_we,
    input  wire [lcdc_pkg::MASK_W-1:0] cfg_wdata
);

    import lcdc_pkg::*;

    // input fields
    logic [OP_W-1:0]   in_op;
    logic [ROWF_W-1:0] in_row;
    logic [COLF_W-1:0] in_col;
    logic [LAYF_W-1:0] in_layer;
    logic [CHAR_W-1:0] in_char;

    assign in_op    = s_tdata[2:0];
    assign in_row   = s_tdata[4:3];
    assign in_col   = s_tdata[10:5];
    assign in_layer = s_tdata[12:11];
    assign in_char  = s_tdata[20:13];

    // state registers
    state_t             state_reg, state_next;
    logic [MASK_W-1:0]  mask_reg;
    logic [ROWF_W-1:0]  cur_row_reg;
    logic [COLF_W-1:0]  cur_col_reg;
    logic [ROW_W-1:0]   r_reg;
    logic [COL_W-1:0]   c_reg;
    logic               repos_reg;
    logic [7:0]         comp_reg, comp_next;

    // memories and their valid bits
    lanes_t     lay_mem [CELLS];
    lanes_t     lay_rd_reg;
    logic [7:0] shown_mem [CELLS];
    logic [7:0] shown_rd_reg;
    logic       lay_vld_reg [LAYERS][ROWS][COLS];
    logic       shown_vld_reg [ROWS][COLS];

    // output register
    logic       m_tvalid_reg;
    logic [7:0] m_byte_reg;
    logic       m_rs_reg;
    logic       m_last_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_rs_reg;
    assign m_tlast  = m_last_reg;

    // input decode
    logic              accept;
    logic              row_ok, col_ok, layer_ok;
    logic [CELL_W-1:0] in_cell;
    logic [ROW_W-1:0]  in_row_idx;
    logic [LAY_W-1:0]  in_lay_idx;

    assign accept     = s_tvalid && s_tready;
    assign row_ok     = (in_row != '0) && (32'(in_row) <= ROWS);
    assign col_ok     = (in_col != '0) && (32'(in_col) <= COLS);
    assign layer_ok   = 32'(in_layer) < LAYERS;
    assign in_cell    = CELL_W'((32'(in_row) - 1) * COLS + 32'(in_col) - 1);
    assign in_row_idx = ROW_W'(in_row - 2'd1);
    assign in_lay_idx = LAY_W'(in_layer);

    // walk position
    logic [CELL_W-1:0] walk_cell;
    logic [7:0]        row_base;
    logic              at_row_end, at_end;
    state_t            adv_state;

    assign walk_cell  = CELL_W'(32'(r_reg) * COLS + 32'(c_reg));
    assign row_base   = (r_reg == '0) ? 8'h00 : ROW1_BASE;
    assign at_row_end = c_reg == COL_W'(COLS - 1);
    assign at_end     = at_row_end && (r_reg == ROW_W'(ROWS - 1));
    assign adv_state  = at_end ? ST_CURSOR : (at_row_end ? ST_ROWCMD : ST_READ);

    // cursor command byte
    logic [7:0] cur_base, cur_cmd;
    assign cur_base = (cur_row_reg == 2'd1) ? 8'h00 : ROW1_BASE;
    assign cur_cmd  = ADDR_CMD | ((cur_base + {2'b00, cur_col_reg} - 8'd1) & ADDR_MASK);

    // composite of visible layers, highest non-space wins
    logic [7:0] mask_ext;
    logic [7:0] shown_val;
    logic       differs;
    assign mask_ext = {{(8 - MASK_W){1'b0}}, mask_reg};

    always_comb begin
        comp_next = SPACE_CODE;
        for (int l = 0; l < LAYERS; l++) begin
            if (!((l < MASK_W) && mask_ext[l]) && lay_vld_reg[l][r_reg][c_reg]
                && (lay_rd_reg[l] != SPACE_CODE)) begin
                comp_next = lay_rd_reg[l];
            end
        end
    end

    assign shown_val = shown_vld_reg[r_reg][c_reg] ? shown_rd_reg : SPACE_CODE;
    assign differs   = comp_next != shown_val;

    logic slot_free;
    assign slot_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && in_op == OP_REFRESH) begin
                    state_next = ST_ROWCMD;
                end else if (accept && in_op == OP_MOVE_CURSOR && row_ok && col_ok) begin
                    state_next = ST_CURSOR;
                end
            end
            ST_ROWCMD: begin
                if (slot_free) state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (differs) state_next = repos_reg ? ST_REPOS : ST_DATA;
                else state_next = adv_state;
            end
            ST_REPOS: begin
                if (slot_free) state_next = ST_DATA;
            end
            ST_DATA: begin
                if (slot_free) state_next = adv_state;
            end
            ST_CURSOR: begin
                if (slot_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    logic       out_load, out_rs, out_last, rd_en, shown_we;
    logic [7:0] out_byte;

    always_comb begin
        s_tready = 1'b0;
        out_load = 1'b0;
        out_rs   = 1'b0;
        out_last = 1'b0;
        out_byte = 8'h00;
        rd_en    = 1'b0;
        shown_we = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_ROWCMD: begin
                out_load = slot_free;
                out_byte = ADDR_CMD | (row_base & ADDR_MASK);
            end
            ST_READ: begin
                rd_en = 1'b1;
            end
            ST_CMP: begin
                rd_en = 1'b0;
            end
            ST_REPOS: begin
                out_load = slot_free;
                out_byte = ADDR_CMD | ((row_base + 8'(c_reg)) & ADDR_MASK);
            end
            ST_DATA: begin
                out_load = slot_free;
                out_rs   = 1'b1;
                out_byte = comp_reg;
                shown_we = slot_free;
            end
            ST_CURSOR: begin
                out_load = slot_free;
                out_last = 1'b1;
                out_byte = cur_cmd;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mask_reg     <= '0;
            cur_row_reg  <= 2'd1;
            cur_col_reg  <= 6'd1;
            r_reg        <= '0;
            c_reg        <= '0;
            repos_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) mask_reg <= cfg_wdata;

            // cursor position
            if (accept && in_op == OP_MOVE_CURSOR && row_ok && col_ok) begin
                cur_row_reg <= in_row;
                cur_col_reg <= in_col;
            end

            // walk counters and re-address flag
            if (accept && in_op == OP_REFRESH) begin
                r_reg <= '0;
                c_reg <= '0;
            end
            if (state_reg == ST_ROWCMD && slot_free) repos_reg <= 1'b0;
            if (state_reg == ST_REPOS && slot_free) repos_reg <= 1'b0;
            if (state_reg == ST_CMP && !differs) repos_reg <= 1'b1;
            if ((state_reg == ST_CMP && !differs) || (state_reg == ST_DATA && slot_free)) begin
                if (at_row_end) begin
                    c_reg <= '0;
                    if (!at_end) r_reg <= r_reg + ROW_W'(1);
                end else begin
                    c_reg <= c_reg + COL_W'(1);
                end
            end

            // output register
            if (out_load) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    // output payload and composite hold
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_byte_reg <= out_byte;
            m_rs_reg   <= out_rs;
            m_last_reg <= out_last;
        end
        if (state_reg == ST_CMP) comp_reg <= comp_next;
    end

    // layer valid bits: cleared entries read as space
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < LAYERS; l++) begin
                for (int r = 0; r < ROWS; r++) begin
                    for (int c = 0; c < COLS; c++) begin
                        lay_vld_reg[l][r][c] <= 1'b0;
                    end
                end
            end
        end else if (accept && layer_ok) begin
            if (in_op == OP_WRITE_CHAR && row_ok && col_ok) begin
                lay_vld_reg[in_lay_idx][in_row_idx][COL_W'(in_col - 6'd1)] <= 1'b1;
            end else if (in_op == OP_CLEAR_LAYER) begin
                for (int r = 0; r < ROWS; r++) begin
                    for (int c = 0; c < COLS; c++) begin
                        lay_vld_reg[in_lay_idx][r][c] <= 1'b0;
                    end
                end
            end else if (in_op == OP_CLEAR_LINE && row_ok) begin
                for (int c = 0; c < COLS; c++) begin
                    lay_vld_reg[in_lay_idx][in_row_idx][c] <= 1'b0;
                end
            end
        end
    end

    // layer memory: byte-lane write, one registered read
    always_ff @(posedge aclk) begin
        if (accept && in_op == OP_WRITE_CHAR && row_ok && col_ok && layer_ok) begin
            lay_mem[in_cell][in_lay_idx] <= in_char;
        end
        if (rd_en) lay_rd_reg <= lay_mem[walk_cell];
    end

    // shown-copy valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int c = 0; c < COLS; c++) begin
                    shown_vld_reg[r][c] <= 1'b0;
                end
            end
        end else if (shown_we) begin
            shown_vld_reg[r_reg][c_reg] <= 1'b1;
        end
    end

    // shown-copy memory
    always_ff @(posedge aclk) begin
        if (shown_we) shown_mem[walk_cell] <= comp_reg;
        if (rd_en) shown_rd_reg <= shown_mem[walk_cell];
    end

endmodule

`default_nettype wire
